[rtl/stcr_pkg.sv]
// ----------------------------------------------------------------------------
// stcr_pkg: shared definitions of the scaled text cell renderer
// Screen geometry, font layout, input kinds, register indexes and the
// start command that the control logic hands to the cell sequencer.
// ----------------------------------------------------------------------------
package stcr_pkg;

    localparam int SCREEN_WIDTH  = 160;
    localparam int SCREEN_HEIGHT = 80;
    localparam int MAX_SCALE     = 4;

    localparam int GLYPH_FIRST = 32;
    localparam int GLYPH_LAST  = 126;
    localparam int GLYPH_COUNT = GLYPH_LAST - GLYPH_FIRST + 1;
    localparam int GLYPH_AW    = $clog2(GLYPH_COUNT);
    localparam int GLYPH_W     = 40;
    localparam int GLYPH_COLS  = 5;
    localparam int CELL_ROWS   = 7;
    localparam int CELL_COLS   = 6;

    localparam int CHAR_NEWLINE = 10;
    localparam int CHAR_RETURN  = 13;
    localparam int CHAR_SUBST   = 63;

    localparam int KIND_W     = 2;
    localparam int CODE_W     = 8;
    localparam int COORD_W    = 16;
    localparam int COLOR_W    = 16;
    localparam int SCALE_W    = 3;
    localparam int CELL_X_W   = 8;
    localparam int CELL_Y_W   = 7;
    localparam int CELL_DIM_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // working width for unwrapped cursor sums
    localparam int POS_W = COORD_W + 2;
    localparam logic signed [POS_W-1:0] WIDTH_S  = POS_W'(SCREEN_WIDTH);
    localparam logic signed [POS_W-1:0] HEIGHT_S = POS_W'(SCREEN_HEIGHT);

    typedef enum logic [KIND_W-1:0] {
        KIND_CHAR   = 2'd0,
        KIND_CURSOR = 2'd1,
        KIND_GLYPH  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOREGROUND = 2'd0,
        REG_BACKGROUND = 2'd1,
        REG_SCALE      = 2'd2,
        REG_WRAP       = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic                      start;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } draw_cmd_t;

endpackage

[rtl/stcr_if.sv]
// ----------------------------------------------------------------------------
// stcr channel interfaces
// Input item channel and result cell channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface stcr_item_if;
    logic                               valid;
    logic                               ready;
    logic [stcr_pkg::KIND_W-1:0]        kind;
    logic [stcr_pkg::CODE_W-1:0]        char_code;
    logic [stcr_pkg::GLYPH_W-1:0]       glyph_columns;
    logic signed [stcr_pkg::COORD_W-1:0] new_x;
    logic signed [stcr_pkg::COORD_W-1:0] new_y;

    modport source (output valid, kind, char_code, glyph_columns, new_x, new_y,
                    input ready);
    modport sink (input valid, kind, char_code, glyph_columns, new_x, new_y,
                  output ready);
endinterface

interface stcr_cell_if;
    logic                            valid;
    logic                            ready;
    logic [stcr_pkg::CELL_X_W-1:0]   cell_x;
    logic [stcr_pkg::CELL_Y_W-1:0]   cell_y;
    logic [stcr_pkg::CELL_DIM_W-1:0] cell_width;
    logic [stcr_pkg::CELL_DIM_W-1:0] cell_height;
    logic [stcr_pkg::COLOR_W-1:0]    cell_color;
    logic                            last_cell;

    modport source (output valid, cell_x, cell_y, cell_width, cell_height, cell_color,
                    last_cell, input ready);
    modport sink (input valid, cell_x, cell_y, cell_width, cell_height, cell_color,
                  last_cell, output ready);
endinterface

[rtl/stcr_glyph_ram.sv]
// ----------------------------------------------------------------------------
// stcr_glyph_ram: single-port glyph memory
// One write, one read or both per cycle; read data registered.
// ----------------------------------------------------------------------------
module stcr_glyph_ram #(
    parameter int DEPTH = 95,
    parameter int WIDTH = 40,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/stcr_cell_seq.sv]
// ----------------------------------------------------------------------------
// stcr_cell_seq: cell sequencer
// Scans the 7x6 cell grid of one character, one position per cycle while the
// output register is free; clips each cell to screen, loads visible ones there.
// ----------------------------------------------------------------------------
module stcr_cell_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    input  stcr_pkg::draw_cmd_t               cmd,
    input  logic [stcr_pkg::SCALE_W-1:0]      scale,
    input  logic [stcr_pkg::COLOR_W-1:0]      fg_color,
    input  logic [stcr_pkg::COLOR_W-1:0]      bg_color,
    input  logic [stcr_pkg::GLYPH_W-1:0]      glyph,
    output logic                              busy,
    stcr_cell_if.source                       result
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DRAW = 2'b10
    } seq_state_t;

    localparam int PW = stcr_pkg::POS_W;

    seq_state_t        state_reg, state_next;
    logic [2:0]        row_reg, row_next;
    logic [2:0]        col_reg, col_next;
    logic signed [PW-1:0] px_reg, px_next;
    logic signed [PW-1:0] py_reg, py_next;
    logic signed [PW-1:0] xbase_reg, xbase_next;

    logic                                 valid_reg, valid_next;
    logic [stcr_pkg::CELL_X_W-1:0]        cx_reg, cx_next;
    logic [stcr_pkg::CELL_Y_W-1:0]        cy_reg, cy_next;
    logic [stcr_pkg::CELL_DIM_W-1:0]      cw_reg, cw_next;
    logic [stcr_pkg::CELL_DIM_W-1:0]      ch_reg, ch_next;
    logic [stcr_pkg::COLOR_W-1:0]         color_reg, color_next;
    logic                                 last_reg, last_next;

    logic signed [PW-1:0] s_ext;
    logic signed [PW-1:0] px_end, py_end;
    logic signed [PW-1:0] x0, x1, y0, y1;
    logic                 visible, right_end, bottom_end, is_last, scan_end;
    logic                 out_free, step, emit, glyph_lit;

    function automatic logic glyph_bit(input logic [stcr_pkg::GLYPH_W-1:0] g,
                                       input logic [2:0] c, input logic [2:0] r);
        logic [7:0] col_byte;
        begin
            unique case (c)
                3'd0:    col_byte = g[7:0];
                3'd1:    col_byte = g[15:8];
                3'd2:    col_byte = g[23:16];
                3'd3:    col_byte = g[31:24];
                3'd4:    col_byte = g[39:32];
                default: col_byte = 8'd0;   // spacing column
            endcase
            return col_byte[r];
        end
    endfunction

    assign s_ext  = PW'($signed({1'b0, scale}));
    assign px_end = px_reg + s_ext;
    assign py_end = py_reg + s_ext;

    assign x0 = (px_reg < 0) ? '0 : px_reg;
    assign x1 = (px_end > stcr_pkg::WIDTH_S) ? stcr_pkg::WIDTH_S : px_end;
    assign y0 = (py_reg < 0) ? '0 : py_reg;
    assign y1 = (py_end > stcr_pkg::HEIGHT_S) ? stcr_pkg::HEIGHT_S : py_end;

    assign visible = (px_end > 0) && (px_reg < stcr_pkg::WIDTH_S)
                  && (py_end > 0) && (py_reg < stcr_pkg::HEIGHT_S);

    // visible cells form a rectangle, so the last one is at its lower right
    assign right_end  = (col_reg == 3'(stcr_pkg::CELL_COLS - 1))
                     || (px_end >= stcr_pkg::WIDTH_S);
    assign bottom_end = (row_reg == 3'(stcr_pkg::CELL_ROWS - 1))
                     || (py_end >= stcr_pkg::HEIGHT_S);
    assign is_last    = visible && right_end && bottom_end;
    assign scan_end   = (row_reg == 3'(stcr_pkg::CELL_ROWS - 1))
                     && (col_reg == 3'(stcr_pkg::CELL_COLS - 1));

    assign out_free  = !valid_reg || result.ready;
    assign step      = (state_reg == ST_DRAW) && out_free;
    assign emit      = step && visible;
    assign glyph_lit = glyph_bit(glyph, col_reg, row_reg);

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        xbase_next = xbase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = ST_DRAW;
                    row_next   = '0;
                    col_next   = '0;
                    px_next    = PW'($signed(cmd.x));
                    py_next    = PW'($signed(cmd.y));
                    xbase_next = PW'($signed(cmd.x));
                end
            end
            ST_DRAW:
            begin
                if (step)
                begin
                    if (is_last || scan_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (col_reg == 3'(stcr_pkg::CELL_COLS - 1))
                    begin
                        col_next = '0;
                        row_next = row_reg + 3'd1;
                        px_next  = xbase_reg;
                        py_next  = py_end;
                    end
                    else
                    begin
                        col_next = col_reg + 3'd1;
                        px_next  = px_end;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cw_next    = cw_reg;
        ch_next    = ch_reg;
        color_next = color_reg;
        last_next  = last_reg;
        if (emit)
        begin
            valid_next = 1'b1;
            cx_next    = stcr_pkg::CELL_X_W'(x0);
            cy_next    = stcr_pkg::CELL_Y_W'(y0);
            cw_next    = stcr_pkg::CELL_DIM_W'(x1 - x0);
            ch_next    = stcr_pkg::CELL_DIM_W'(y1 - y0);
            color_next = glyph_lit ? fg_color : bg_color;
            last_next  = is_last;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg   <= row_next;
        col_reg   <= col_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        xbase_reg <= xbase_next;
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        cw_reg    <= cw_next;
        ch_reg    <= ch_next;
        color_reg <= color_next;
        last_reg  <= last_next;
    end

    assign busy               = (state_reg == ST_DRAW);
    assign result.valid       = valid_reg;
    assign result.cell_x      = cx_reg;
    assign result.cell_y      = cy_reg;
    assign result.cell_width  = cw_reg;
    assign result.cell_height = ch_reg;
    assign result.cell_color  = color_reg;
    assign result.last_cell   = last_reg;

endmodule

[rtl/scaled_text_cell_renderer_core.sv]
// ----------------------------------------------------------------------------
// scaled_text_cell_renderer_core: 5x7 font text engine
// Keeps the text cursor and the glyph memory, handles control codes and
// wrap, and starts the cell sequencer for each drawn character.
// ----------------------------------------------------------------------------
//  channel   dir  transfer moves
//  item      in   kind, char_code, glyph_columns, new_x, new_y
//  result    out  cell_x, cell_y, cell_width, cell_height, cell_color, last_cell
//  cfg       in   cfg_write_enable, cfg_index, cfg_data (write only)
//
//  Cursor set, glyph load, control codes and dropped characters do not start
//  the sequencer. For a drawn character the sequencer visits one grid position
//  per cycle and stops after the last visible cell, or at the grid's end if none.
//  Result stalls hold the sequencer; item.ready is low while it draws.
//  Reset zeroes the cursor, presets the registers, leaves the glyph memory.
// ----------------------------------------------------------------------------
module scaled_text_cell_renderer_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_enable,
    input  logic [stcr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [stcr_pkg::CFG_DATA_W-1:0]   cfg_data,
    stcr_item_if.sink                         item,
    stcr_cell_if.source                       result
);

    localparam int PW = stcr_pkg::POS_W;

    logic [stcr_pkg::COLOR_W-1:0]  fg_reg, fg_next;
    logic [stcr_pkg::COLOR_W-1:0]  bg_reg, bg_next;
    logic [stcr_pkg::SCALE_W-1:0]  scale_reg, scale_next;
    logic                          wrap_reg, wrap_next;
    logic signed [stcr_pkg::COORD_W-1:0] col_reg, col_next;
    logic signed [stcr_pkg::COORD_W-1:0] row_reg, row_next;

    logic [stcr_pkg::SCALE_W-1:0]  scale_wr;
    logic                          accept, busy;
    logic                          is_char, is_glyph, is_cursor;
    logic                          code_ok, is_nl, is_cr, wrap_hit, below, above;
    logic [stcr_pkg::CODE_W-1:0]   draw_code, ram_code;
    logic [stcr_pkg::GLYPH_AW-1:0] ram_addr;
    logic [stcr_pkg::GLYPH_W-1:0]  glyph;
    logic signed [PW-1:0]          s_ext, s6, s7, s8, col_ext, row_ext, yw_ext;
    logic signed [stcr_pkg::COORD_W-1:0] row_nl, x_w, y_w, col_adv;
    stcr_pkg::draw_cmd_t           cmd;

    assign accept    = item.valid && item.ready;
    assign item.ready = !busy;
    assign is_char   = (item.kind == stcr_pkg::KIND_CHAR);
    assign is_glyph  = (item.kind == stcr_pkg::KIND_GLYPH);
    assign is_cursor = (item.kind == stcr_pkg::KIND_CURSOR);

    assign code_ok   = (item.char_code >= stcr_pkg::CODE_W'(stcr_pkg::GLYPH_FIRST))
                    && (item.char_code <= stcr_pkg::CODE_W'(stcr_pkg::GLYPH_LAST));
    assign is_nl     = (item.char_code == stcr_pkg::CODE_W'(stcr_pkg::CHAR_NEWLINE));
    assign is_cr     = (item.char_code == stcr_pkg::CODE_W'(stcr_pkg::CHAR_RETURN));
    assign draw_code = code_ok ? item.char_code : stcr_pkg::CODE_W'(stcr_pkg::CHAR_SUBST);
    assign ram_code  = is_glyph ? item.char_code : draw_code;
    assign ram_addr  = stcr_pkg::GLYPH_AW'(ram_code
                                           - stcr_pkg::CODE_W'(stcr_pkg::GLYPH_FIRST));

    // cursor edge tests run on unwrapped sums
    assign s_ext   = PW'($signed({1'b0, scale_reg}));
    assign s6      = PW'(6) * s_ext;
    assign s7      = PW'(7) * s_ext;
    assign s8      = PW'(8) * s_ext;
    assign col_ext = PW'(col_reg);
    assign row_ext = PW'(row_reg);
    assign row_nl  = stcr_pkg::COORD_W'(row_ext + s8);

    assign wrap_hit = wrap_reg && ((col_ext + s6) > stcr_pkg::WIDTH_S);
    assign x_w      = wrap_hit ? '0 : col_reg;
    assign y_w      = wrap_hit ? row_nl : row_reg;
    assign yw_ext   = PW'(y_w);
    assign below    = (yw_ext >= stcr_pkg::HEIGHT_S);
    assign above    = ((yw_ext + s7) <= 0);
    assign col_adv  = stcr_pkg::COORD_W'(PW'(x_w) + s6);

    assign cmd.start = accept && is_char && !is_nl && !is_cr && !below && !above;
    assign cmd.x     = x_w;
    assign cmd.y     = y_w;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (is_cursor)
            begin
                col_next = item.new_x;
                row_next = item.new_y;
            end
            else if (is_char)
            begin
                priority if (is_nl)
                begin
                    col_next = '0;
                    row_next = row_nl;
                end
                else if (is_cr)
                begin
                    col_next = '0;
                end
                else if (below)
                begin
                    col_next = x_w;
                    row_next = y_w;
                end
                else
                begin
                    col_next = col_adv;
                    row_next = y_w;
                end
            end
        end
    end

    // clamp scale to 1..MAX_SCALE
    always_comb
    begin
        scale_wr = cfg_data[stcr_pkg::SCALE_W-1:0];
        if (scale_wr == '0)
        begin
            scale_wr = stcr_pkg::SCALE_W'(1);
        end
        else if (scale_wr > stcr_pkg::SCALE_W'(stcr_pkg::MAX_SCALE))
        begin
            scale_wr = stcr_pkg::SCALE_W'(stcr_pkg::MAX_SCALE);
        end
    end

    always_comb
    begin
        fg_next    = fg_reg;
        bg_next    = bg_reg;
        scale_next = scale_reg;
        wrap_next  = wrap_reg;
        if (cfg_write_enable)
        begin
            unique case (cfg_index)
                stcr_pkg::REG_FOREGROUND: fg_next    = cfg_data;
                stcr_pkg::REG_BACKGROUND: bg_next    = cfg_data;
                stcr_pkg::REG_SCALE:      scale_next = scale_wr;
                stcr_pkg::REG_WRAP:       wrap_next  = cfg_data[0];
                default:                  fg_next    = fg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg    <= '1;
            bg_reg    <= '0;
            scale_reg <= stcr_pkg::SCALE_W'(1);
            wrap_reg  <= 1'b1;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            fg_reg    <= fg_next;
            bg_reg    <= bg_next;
            scale_reg <= scale_next;
            wrap_reg  <= wrap_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    stcr_glyph_ram #(
        .DEPTH (stcr_pkg::GLYPH_COUNT),
        .WIDTH (stcr_pkg::GLYPH_W)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (accept && is_glyph && code_ok),
        .re    (accept && is_char),
        .addr  (ram_addr),
        .wdata (item.glyph_columns),
        .rdata (glyph)
    );

    stcr_cell_seq u_cell_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .scale    (scale_reg),
        .fg_color (fg_reg),
        .bg_color (bg_reg),
        .glyph    (glyph),
        .busy     (busy),
        .result   (result)
    );

endmodule

[rtl/stcr_checker.sv]
// ----------------------------------------------------------------------------
// stcr_checker: port-level checks of the text cell renderer
// Watches the item and result channels of the top level.
// ----------------------------------------------------------------------------
module stcr_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              item_ready,
    input logic                              res_valid,
    input logic                              res_ready,
    input logic [stcr_pkg::CELL_X_W-1:0]     cell_x,
    input logic [stcr_pkg::CELL_Y_W-1:0]     cell_y,
    input logic [stcr_pkg::CELL_DIM_W-1:0]   cell_width,
    input logic [stcr_pkg::CELL_DIM_W-1:0]   cell_height,
    input logic [stcr_pkg::COLOR_W-1:0]      cell_color,
    input logic                              last_cell
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(cell_x) && $stable(cell_y)
            && $stable(cell_width) && $stable(cell_height) && $stable(cell_color)
            && $stable(last_cell))
        else $error("result changed while stalled");

    a_dims: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> cell_width >= 3'd1 && cell_height >= 3'd1
            && cell_width <= stcr_pkg::CELL_DIM_W'(stcr_pkg::MAX_SCALE)
            && cell_height <= stcr_pkg::CELL_DIM_W'(stcr_pkg::MAX_SCALE))
        else $error("cell size out of range");

    a_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (12'(cell_x) + 12'(cell_width) <= 12'(stcr_pkg::SCREEN_WIDTH))
            && (12'(cell_y) + 12'(cell_height) <= 12'(stcr_pkg::SCREEN_HEIGHT)))
        else $error("cell not clipped to screen");

    a_char_open: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !last_cell |-> !item_ready)
        else $error("item taken while a character is still drawing");

endmodule

bind scaled_text_cell_renderer_core stcr_checker u_stcr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_ready  (item.ready),
    .res_valid   (result.valid),
    .res_ready   (result.ready),
    .cell_x      (result.cell_x),
    .cell_y      (result.cell_y),
    .cell_width  (result.cell_width),
    .cell_height (result.cell_height),
    .cell_color  (result.cell_color),
    .last_cell   (result.last_cell)
);

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench of the scaled text cell renderer core
// Drives glyph loads, cursor sets and characters into the item channel and
// computes the cells to expect from the cursor, the glyphs and the registers.
// Each returned cell is compared field by field with the oldest one pending.
// Register settings run from the reset values through both color extremes,
// every scale, clamped scale writes and wrap on and off. Both channels idle
// at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import stcr_pkg::*;

    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 12;
    // one full 42-position scan of a character plus margin
    localparam int DRAIN_CYCLES   = 48;
    // limit on a quiet stretch with no transfer on either channel
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [CELL_X_W-1:0]   x;
        logic [CELL_Y_W-1:0]   y;
        logic [CELL_DIM_W-1:0] width;
        logic [CELL_DIM_W-1:0] height;
        logic [COLOR_W-1:0]    color;
        logic                  is_last;
    } cell_t;

    class renderer_scoreboard;
        logic [COLOR_W-1:0]        fg_color;
        logic [COLOR_W-1:0]        bg_color;
        int                        scale_factor;
        bit                        wrap_on;
        logic signed [COORD_W-1:0] col;
        logic signed [COORD_W-1:0] row;
        logic [GLYPH_W-1:0]        glyph_rom [GLYPH_COUNT];
        cell_t                     pending_cells [$];
        int                        error_count;
        int                        cells_checked;

        function new();
            fg_color      = '1;
            bg_color      = '0;
            scale_factor  = 1;
            wrap_on       = 1'b1;
            col           = '0;
            row           = '0;
            error_count   = 0;
            cells_checked = 0;
            foreach (glyph_rom[i])
                glyph_rom[i] = '0;
        endfunction

        function void write_register(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_FOREGROUND: fg_color = data;
                REG_BACKGROUND: bg_color = data;
                REG_SCALE:
                begin
                    scale_factor = data[SCALE_W-1:0];
                    if (scale_factor == 0)
                        scale_factor = 1;
                    if (scale_factor > MAX_SCALE)
                        scale_factor = MAX_SCALE;
                end
                REG_WRAP:       wrap_on = data[0];
                default: ;
            endcase
        endfunction

        function void draw_item(kind_t kind, logic [CODE_W-1:0] code,
                                logic [GLYPH_W-1:0] columns,
                                logic signed [COORD_W-1:0] nx,
                                logic signed [COORD_W-1:0] ny);
            int                 x;
            int                 y;
            int                 s;
            int                 px;
            int                 py;
            int                 x0;
            int                 x1;
            int                 y0;
            int                 y1;
            logic [CODE_W-1:0]  ch;
            logic [GLYPH_W-1:0] bits;
            cell_t              piece;
            cell_t              drawn [$];
            s  = scale_factor;
            ch = code;
            if (kind == KIND_CURSOR)
            begin
                col = nx;
                row = ny;
            end
            else if (kind == KIND_GLYPH)
            begin
                if (code >= GLYPH_FIRST && code <= GLYPH_LAST)
                    glyph_rom[code - GLYPH_FIRST] = columns;
            end
            else if (kind == KIND_CHAR)
            begin
                x = col;
                y = row;
                if (ch == CHAR_NEWLINE)
                begin
                    col = '0;
                    row = 16'(y + 8 * s);
                end
                else if (ch == CHAR_RETURN)
                    col = '0;
                else
                begin
                    if (ch < GLYPH_FIRST || ch > GLYPH_LAST)
                        ch = CHAR_SUBST;
                    // edge tests use the unwrapped sum, the cursor itself wraps
                    if (wrap_on && x + 6 * s > SCREEN_WIDTH)
                    begin
                        x   = 0;
                        row = 16'(y + 8 * s);
                        y   = row;
                        col = '0;
                    end
                    if (y >= SCREEN_HEIGHT)
                        ; // below the screen: drop, cursor holds
                    else if (y + 7 * s <= 0)
                        col = 16'(x + 6 * s);
                    else
                    begin
                        bits = glyph_rom[ch - GLYPH_FIRST];
                        for (int r = 0; r < CELL_ROWS; r++)
                        begin
                            for (int c = 0; c < CELL_COLS; c++)
                            begin
                                px = x + c * s;
                                py = y + r * s;
                                x0 = (px > 0) ? px : 0;
                                x1 = (px + s < SCREEN_WIDTH) ? px + s : SCREEN_WIDTH;
                                y0 = (py > 0) ? py : 0;
                                y1 = (py + s < SCREEN_HEIGHT) ? py + s : SCREEN_HEIGHT;
                                if (x1 <= x0 || y1 <= y0)
                                    continue;
                                piece.x       = 8'(x0);
                                piece.y       = 7'(y0);
                                piece.width   = 3'(x1 - x0);
                                piece.height  = 3'(y1 - y0);
                                // the spacing column is always background
                                piece.color   = (c < GLYPH_COLS && bits[c * 8 + r]) ?
                                                fg_color : bg_color;
                                piece.is_last = 1'b0;
                                drawn.push_back(piece);
                            end
                        end
                        if (drawn.size() > 0)
                            drawn[drawn.size() - 1].is_last = 1'b1;
                        foreach (drawn[i])
                            pending_cells.push_back(drawn[i]);
                        col = 16'(x + 6 * s);
                    end
                end
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                error_count++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_cell(cell_t got);
            cell_t want;
            cells_checked++;
            if (pending_cells.size() == 0)
            begin
                error_count++;
                $display("%0t: cell with none pending, expected nothing, got x=%0d y=%0d",
                         $time, got.x, got.y);
            end
            else
            begin
                want = pending_cells.pop_front();
                compare_field("cell_x", want.x, got.x);
                compare_field("cell_y", want.y, got.y);
                compare_field("cell_width", want.width, got.width);
                compare_field("cell_height", want.height, got.height);
                compare_field("cell_color", want.color, got.color);
                compare_field("last_cell", want.is_last, got.is_last);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_write_enable;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    stcr_item_if item_ch ();
    stcr_cell_if cell_ch ();

    renderer_scoreboard board;
    bit                 glyph_loaded [GLYPH_COUNT];
    bit                 no_idle;
    int                 items_sent;
    int                 chars_sent;
    int                 quiet_cycles;

    scaled_text_cell_renderer_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .item             (item_ch),
        .result           (cell_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic logic [GLYPH_W-1:0] rand40();
        return {8'($urandom), $urandom};
    endfunction

    function automatic logic signed [COORD_W-1:0] rand16();
        return 16'($urandom);
    endfunction

    task automatic send_item(kind_t kind, logic [CODE_W-1:0] code,
                             logic [GLYPH_W-1:0] columns,
                             logic signed [COORD_W-1:0] nx,
                             logic signed [COORD_W-1:0] ny);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.kind          <= kind;
        item_ch.char_code     <= code;
        item_ch.glyph_columns <= columns;
        item_ch.new_x         <= nx;
        item_ch.new_y         <= ny;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        board.draw_item(kind, code, columns, nx, ny);
        if (kind == KIND_GLYPH && code >= GLYPH_FIRST && code <= GLYPH_LAST)
            glyph_loaded[code - GLYPH_FIRST] = 1'b1;
        if (kind == KIND_CHAR)
            chars_sent++;
        items_sent++;
    endtask

    // load the glyph a character will read first if it was never written
    task automatic send_char(logic [CODE_W-1:0] code);
        int idx;
        if (code != CHAR_NEWLINE && code != CHAR_RETURN)
        begin
            idx = (code >= GLYPH_FIRST && code <= GLYPH_LAST) ?
                  code - GLYPH_FIRST : CHAR_SUBST - GLYPH_FIRST;
            if (!glyph_loaded[idx])
                send_item(KIND_GLYPH, 8'(idx + GLYPH_FIRST), rand40(), rand16(), rand16());
        end
        send_item(KIND_CHAR, code, rand40(), rand16(), rand16());
    endtask

    task automatic move_cursor(int nx, int ny);
        send_item(KIND_CURSOR, 8'($urandom), rand40(), 16'(nx), 16'(ny));
    endtask

    task automatic random_item(output bit useful);
        int                        pick;
        int                        sel;
        bit                        off_screen;
        logic [CODE_W-1:0]         code;
        logic signed [COORD_W-1:0] nx;
        logic signed [COORD_W-1:0] ny;
        pick       = $urandom_range(0, 99);
        off_screen = board.row >= SCREEN_HEIGHT || board.row < -30;
        useful     = 1'b1;
        if (pick < 8)
        begin
            code = ($urandom_range(0, 4) == 0) ? 8'($urandom) :
                   8'($urandom_range(GLYPH_FIRST, GLYPH_LAST));
            useful = code >= GLYPH_FIRST && code <= GLYPH_LAST;
            send_item(KIND_GLYPH, code, rand40(), rand16(), rand16());
        end
        else if (pick < 20 || (off_screen && pick < 60))
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                nx = rand16();
                ny = rand16();
            end
            else
            begin
                nx = 16'(int'($urandom_range(0, 200)) - 30);
                ny = 16'(int'($urandom_range(0, 130)) - 40);
            end
            send_item(KIND_CURSOR, 8'($urandom), rand40(), nx, ny);
        end
        else if (pick < 23)
        begin
            useful = 1'b0;
            send_item(KIND_NONE, 8'($urandom), rand40(), rand16(), rand16());
        end
        else
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
                send_char(8'(CHAR_NEWLINE));
            else if (sel < 12)
                send_char(8'(CHAR_RETURN));
            else if (sel < 22)
                send_char(8'($urandom));
            else
                send_char(8'($urandom_range(GLYPH_FIRST, GLYPH_LAST)));
        end
    endtask

    task automatic write_registers(logic [CFG_DATA_W-1:0] fg, logic [CFG_DATA_W-1:0] bg,
                                   logic [CFG_DATA_W-1:0] sc, logic [CFG_DATA_W-1:0] wr);
        reg_index_t            order [4];
        logic [CFG_DATA_W-1:0] data [4];
        order = '{REG_FOREGROUND, REG_BACKGROUND, REG_SCALE, REG_WRAP};
        data  = '{fg, bg, sc, wr};
        for (int i = 0; i < 4; i++)
        begin
            cfg_write_enable <= 1'b1;
            cfg_index        <= order[i];
            cfg_data         <= data[i];
            @(posedge clk);
            board.write_register(order[i], data[i]);
        end
        cfg_write_enable <= 1'b0;
    endtask

    // hold the sender until every pending cell is back, then let the block go idle
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_cells.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic directed_items();
        send_item(KIND_GLYPH, 8'(GLYPH_LAST), '1, '0, '0);
        send_item(KIND_GLYPH, 8'(GLYPH_FIRST), '0, '0, '0);
        send_item(KIND_GLYPH, 8'(CHAR_SUBST), 40'h06_09_51_01_02, '0, '0);
        send_item(KIND_GLYPH, 8'(GLYPH_FIRST - 1), rand40(), rand16(), rand16());
        send_item(KIND_GLYPH, 8'(GLYPH_LAST + 1), rand40(), rand16(), rand16());
        send_item(KIND_NONE, '1, '1, 16'sh7FFF, 16'sh8000);
        move_cursor(0, 0);
        send_char(8'(GLYPH_LAST));
        send_char(8'(GLYPH_FIRST));
        send_char(8'(CHAR_NEWLINE));
        send_char(8'(CHAR_RETURN));
        send_char(8'h00);
        send_char(8'hFF);
        // right-edge wrap, clipping at top, left and bottom, off-screen drops
        move_cursor(155, 0);
        send_char(8'(GLYPH_LAST));
        move_cursor(-3, -3);
        send_char(8'(CHAR_SUBST));
        move_cursor(100, 76);
        send_char(8'(GLYPH_LAST));
        move_cursor(10, SCREEN_HEIGHT);
        send_char(8'(GLYPH_LAST));
        move_cursor(10, -7);
        send_char(8'(GLYPH_LAST));
        move_cursor(-6, 10);
        send_char(8'(GLYPH_LAST));
        move_cursor(32767, 32767);
        send_char(8'(CHAR_NEWLINE));
        send_char(8'(GLYPH_LAST));
    endtask

    initial
    begin
        bit useful;
        int count;
        board            = new();
        no_idle          = 1'b0;
        items_sent       = 0;
        chars_sent       = 0;
        rst_n            = 1'b0;
        item_ch.valid         <= 1'b0;
        item_ch.kind          <= KIND_NONE;
        item_ch.char_code     <= '0;
        item_ch.glyph_columns <= '0;
        item_ch.new_x         <= '0;
        item_ch.new_y         <= '0;
        cfg_write_enable      <= 1'b0;
        cfg_index             <= REG_FOREGROUND;
        cfg_data              <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        directed_items();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase)
                0:       write_registers(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
                1:       write_registers(16'hFFFF, 16'h0000, 16'h0007, 16'h0001);
                2:       write_registers(16'($urandom), 16'($urandom), 16'h0004, 16'h0000);
                3:       write_registers(16'($urandom), 16'($urandom), 16'h0002, 16'h0001);
                4:       write_registers(16'($urandom), 16'($urandom), 16'h0003, 16'h0000);
                default: write_registers(16'($urandom), 16'($urandom), 16'($urandom),
                                         16'($urandom));
            endcase
            no_idle = (phase == 1) || ($urandom_range(0, 3) == 0);
            count   = 0;
            while (count < PHASE_ITEMS)
            begin
                random_item(useful);
                if (useful)
                    count++;
            end
        end

        drain();
        $display("Sent %0d items, %0d of them characters, and checked %0d cells.",
                 items_sent, chars_sent, board.cells_checked);
        $display("Settings covered scales 1 to 4, clamped scale writes, wrap on and off.");
        if (board.error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // result side: stall a random number of cycles before each cell
    initial
    begin
        int stall;
        cell_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = idle_cycles();
            if (stall > 0)
            begin
                cell_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            cell_ch.ready <= 1'b1;
            @(posedge clk);
            while (!cell_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cell_t seen;
        if (rst_n && cell_ch.valid && cell_ch.ready)
        begin
            seen.x       = cell_ch.cell_x;
            seen.y       = cell_ch.cell_y;
            seen.width   = cell_ch.cell_width;
            seen.height  = cell_ch.cell_height;
            seen.color   = cell_ch.cell_color;
            seen.is_last = cell_ch.last_cell;
            board.check_cell(seen);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_ch.valid && item_ch.ready) || (cell_ch.valid && cell_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d cells pending",
                         $time, quiet_cycles, board.pending_cells.size());
                $display("RESULT: ERROR");
                $finish;
            end
        end
        else
            quiet_cycles = 0;
    end

endmodule
